### design/sysex_pkg.sv
// Shared types and constants for the SysEx 7-bit pack/unpack codec.
package sysex_pkg;

  localparam logic [7:0] SYSEX_OPEN  = 8'hF0;
  localparam logic [7:0] SYSEX_CLOSE = 8'hF7;
  localparam int unsigned GROUP_LEN  = 7;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_END   = 2'd2;

  localparam logic ACT_UNPACK = 1'b0;
  localparam logic ACT_PACK   = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_message;
    logic [1:0] status;
  } out_word_t;

  typedef struct packed {
    logic                      open;
    logic                      grp;
    logic [7:0]                hdr;
    logic [2:0]                cnt;
    logic [GROUP_LEN-1:0][6:0] data;
    logic                      tail;
    out_word_t                 tail_word;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_NEW,
    BK_HDR,
    BK_DATA,
    BK_TAIL
  } bk_state_t;

  typedef enum logic [1:0] {
    K_OPEN,
    K_HDR,
    K_DATA,
    K_TAIL
  } word_kind_t;

endpackage

### design/sysex_front.sv
// Front end: accept input words, track message state, issue output commands.
module sysex_front import sysex_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_word,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  logic       msg_r, msg_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic [7:0] hdr_r, hdr_nxt;
  logic       serr_r, serr_nxt;
  logic [6:0] store_r [GROUP_LEN];
  logic       wr_en;
  logic [2:0] wr_idx;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic [2:0] p;
    logic [7:0] h;
    logic [3:0] np;
    logic [2:0] pm1;
    msg_nxt  = msg_r;
    pos_nxt  = pos_r;
    hdr_nxt  = hdr_r;
    serr_nxt = serr_r;
    wr_en    = 1'b0;
    wr_idx   = pos_r;
    q_cmd    = '0;
    p        = pos_r;
    h        = hdr_r;
    np       = '0;
    pm1      = pos_r - 3'd1;
    if (in_word.action == ACT_PACK) begin
      if (!msg_r) begin
        q_cmd.open = 1'b1;
        q_cmd.tail_word = '0;
        p = '0;
        h = '0;
      end
      if (p == 3'd7) begin
        p = '0;
        h = '0;
      end
      wr_en  = 1'b1;
      wr_idx = p;
      h      = h | (8'(in_word.data_byte[7]) << p);
      np     = {1'b0, p} + 4'd1;
      for (int i = 0; i < GROUP_LEN; i++) begin
        q_cmd.data[i] = (3'(i) == p) ? in_word.data_byte[6:0] : store_r[i];
      end
      if (np == 4'(GROUP_LEN) || in_word.last_byte) begin
        q_cmd.grp = 1'b1;
        q_cmd.cnt = np[2:0];
        q_cmd.hdr = h;
        pos_nxt   = '0;
        hdr_nxt   = '0;
      end else begin
        pos_nxt = np[2:0];
        hdr_nxt = h;
      end
      if (in_word.last_byte) begin
        q_cmd.tail      = 1'b1;
        q_cmd.tail_word = '{SYSEX_CLOSE, 1'b1, 1'b1, ST_OK};
        msg_nxt  = 1'b0;
        pos_nxt  = '0;
        hdr_nxt  = '0;
        serr_nxt = 1'b0;
      end else begin
        msg_nxt = 1'b1;
      end
    end else begin
      if (!msg_r) begin
        serr_nxt = (in_word.data_byte != SYSEX_OPEN);
        msg_nxt  = 1'b1;
        pos_nxt  = '0;
        hdr_nxt  = '0;
        if (in_word.last_byte) begin
          q_cmd.tail      = 1'b1;
          q_cmd.tail_word = '{8'h00, 1'b0, 1'b1, ST_START};
          msg_nxt  = 1'b0;
          serr_nxt = 1'b0;
        end
      end else if (in_word.last_byte) begin
        q_cmd.tail = 1'b1;
        q_cmd.tail_word = '{8'h00, 1'b0, 1'b1,
                            serr_r ? ST_START :
                            (in_word.data_byte != SYSEX_CLOSE) ? ST_END : ST_OK};
        msg_nxt  = 1'b0;
        pos_nxt  = '0;
        hdr_nxt  = '0;
        serr_nxt = 1'b0;
      end else begin
        if (pos_r == 3'd0) begin
          hdr_nxt = in_word.data_byte;
        end else begin
          q_cmd.tail = 1'b1;
          q_cmd.tail_word = '{in_word.data_byte | {hdr_r[pm1], 7'h00},
                              1'b1, 1'b0, ST_OK};
        end
        pos_nxt = (pos_r == 3'd7) ? 3'd0 : pos_r + 3'd1;
      end
    end
  end

  assign q_push = accept && (q_cmd.open || q_cmd.grp || q_cmd.tail);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_r  <= 1'b0;
      pos_r  <= '0;
      hdr_r  <= '0;
      serr_r <= 1'b0;
    end else if (accept) begin
      msg_r  <= msg_nxt;
      pos_r  <= pos_nxt;
      hdr_r  <= hdr_nxt;
      serr_r <= serr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      store_r[wr_idx] <= in_word.data_byte[6:0];
    end
  end

endmodule

### design/sysex_queue.sv
// Short command queue between the front and back ends.
module sysex_queue import sysex_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count above depth");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop while empty");

endmodule

### design/sysex_back.sv
// Back end: expand queued commands into output words behind an output register.
module sysex_back import sysex_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  cmd_t      head_cmd,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  bk_state_t  state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r;
  out_word_t  out_word_r;
  word_kind_t kind;
  out_word_t  cur_word;
  logic       fire;
  logic [3:0] idx_inc;

  assign fire    = head_valid && (!out_valid_r || out_ready);
  assign idx_inc = {1'b0, idx_r} + 4'd1;

  always_comb begin
    unique case (state_r)
      BK_NEW:  kind = head_cmd.open ? K_OPEN : head_cmd.grp ? K_HDR : K_TAIL;
      BK_HDR:  kind = K_HDR;
      BK_DATA: kind = K_DATA;
      BK_TAIL: kind = K_TAIL;
      default: kind = K_TAIL;
    endcase
    unique case (kind)
      K_OPEN:  cur_word = '{SYSEX_OPEN, 1'b1, 1'b0, ST_OK};
      K_HDR:   cur_word = '{head_cmd.hdr, 1'b1, 1'b0, ST_OK};
      K_DATA:  cur_word = '{{1'b0, head_cmd.data[idx_r]}, 1'b1, 1'b0, ST_OK};
      K_TAIL:  cur_word = head_cmd.tail_word;
      default: cur_word = head_cmd.tail_word;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    pop       = 1'b0;
    if (fire) begin
      unique case (kind)
        K_OPEN: begin
          if (head_cmd.grp) begin
            state_nxt = BK_HDR;
          end else if (head_cmd.tail) begin
            state_nxt = BK_TAIL;
          end else begin
            state_nxt = BK_NEW;
            pop       = 1'b1;
          end
        end
        K_HDR: begin
          state_nxt = BK_DATA;
          idx_nxt   = '0;
        end
        K_DATA: begin
          if (idx_inc < {1'b0, head_cmd.cnt}) begin
            state_nxt = BK_DATA;
            idx_nxt   = idx_inc[2:0];
          end else if (head_cmd.tail) begin
            state_nxt = BK_TAIL;
          end else begin
            state_nxt = BK_NEW;
            pop       = 1'b1;
          end
        end
        K_TAIL: begin
          state_nxt = BK_NEW;
          pop       = 1'b1;
        end
        default: begin
          state_nxt = BK_NEW;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_NEW;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word_r <= cur_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_data_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (head_valid && state_r == BK_DATA) |-> ({1'b0, idx_r} < {1'b0, head_cmd.cnt}))
    else $error("data index past group length");

  a_status_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.status == ST_OK || out_word_r.end_of_message))
    else $error("error status on a non-closing word");

  a_close_no_byte_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.status != ST_OK) |-> !out_word_r.byte_valid)
    else $error("error status with a byte attached");

endmodule

### design/sysex_7bit_pack_unpack.sv
// Top level of the SysEx 7-bit pack/unpack codec.
// The first output word passes through a command queue entry and then the output register.
// Throughput: one word per cycle while out_ready is high; a packed word yields 0 to 9 outputs.
// Input stalls only when the command queue (QDEPTH entries) is full.
// Reset (rst_n low, synchronous) closes any open message and empties the queue.
// The group byte store is not cleared by reset.
module sysex_7bit_pack_unpack import sysex_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic q_head_valid;
  cmd_t q_head;

  sysex_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  sysex_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head)
  );

  sysex_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_cmd   (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

endmodule
